@@ hw/rtl/mom_pkg.sv @@
package mom_pkg;

    localparam int Q_W          = 32;
    localparam int FRAC         = 28;
    localparam int Z_W          = 40;
    localparam int PROD_W       = 2 * Q_W;
    localparam int CNT_W        = 12;
    localparam int ITER_RST     = 100;
    localparam int MAX_ITER_DEF = 4095;
    localparam int SQ_STEPS     = Q_W;
    localparam int SQ_CNT_W     = $clog2(SQ_STEPS);
    localparam int REM_W        = Q_W + 4;

    typedef struct packed {
        logic signed [Q_W-1:0] c_real;
        logic signed [Q_W-1:0] c_imag;
    } t_in;

    typedef struct packed {
        logic [Q_W-1:0] magnitude;
        logic           escaped;
    } t_out;

    typedef struct packed {
        logic load;
        logic mul;
        logic step;
        logic mark_esc;
        logic sq_init;
        logic sq_step;
        logic res_ld;
    } t_cmd;

    typedef struct packed {
        logic esc;
        logic last;
        logic sq_done;
    } t_sts;

endpackage

@@ hw/rtl/mom_ctrl.sv @@
module mom_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  mom_pkg::t_sts i_sts,
    output mom_pkg::t_cmd o_cmd
);
    import mom_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_UPD  = 5'b00100,
        S_SQRT = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                w_cmd.mul = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                if (i_sts.esc) begin
                    w_cmd.mark_esc = 1'b1;
                    n_state        = S_OUT;
                end else if (i_sts.last) begin
                    w_cmd.sq_init = 1'b1;
                    n_state       = S_SQRT;
                end else begin
                    w_cmd.step = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_SQRT: begin
                w_cmd.sq_step = 1'b1;
                if (i_sts.sq_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.res_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_cmd.res_ld) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ hw/rtl/mom_datapath.sv @@
module mom_datapath #(
    parameter int MAX_ITERATIONS = mom_pkg::MAX_ITER_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [mom_pkg::CNT_W-1:0] i_cfg_data,
    input  mom_pkg::t_in              i_in,
    input  mom_pkg::t_cmd             i_cmd,
    output mom_pkg::t_sts             o_sts,
    output mom_pkg::t_out             o_out
);
    import mom_pkg::*;

    localparam int K_W = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS + 1) : 1;
    localparam int CW  = (K_W > CNT_W) ? K_W : CNT_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ITERATIONS);
    localparam logic [SQ_CNT_W-1:0] SQ_LAST = SQ_CNT_W'(SQ_STEPS - 1);

    logic [CNT_W-1:0]         r_iter_cnt;
    logic signed [Q_W-1:0]    r_cr, r_ci;
    logic signed [Z_W-1:0]    r_re, r_im;
    logic [K_W-1:0]           r_k, r_lim;
    logic [PROD_W-1:0]        r_prr, r_pii, r_pri;
    logic                     r_big, r_neg, r_esc_f;
    logic [PROD_W-1:0]        r_val;
    logic [REM_W-1:0]         r_rem;
    logic [Q_W-1:0]           r_root;
    logic [SQ_CNT_W-1:0]      r_sq_cnt;
    logic [Q_W-1:0]           r_mag;
    logic                     r_escd;

    logic [Z_W-1:0]           w_are, w_aim;
    logic [PROD_W-1:0]        w_prr, w_pii, w_pri;
    logic [PROD_W:0]          w_sum;
    logic signed [Z_W-1:0]    w_p, w_q, w_x, w_nr, w_ni;
    logic [CW-1:0]            w_cfg_ext;
    logic [REM_W-1:0]         w_rem_sh, w_trial;
    logic                     w_ge;

    // magnitudes of z; anything at or above 2^32 has escaped already
    assign w_are = r_re[Z_W-1] ? Z_W'(-r_re) : Z_W'(r_re);
    assign w_aim = r_im[Z_W-1] ? Z_W'(-r_im) : Z_W'(r_im);
    assign w_prr = w_are[Q_W-1:0] * w_are[Q_W-1:0];
    assign w_pii = w_aim[Q_W-1:0] * w_aim[Q_W-1:0];
    assign w_pri = w_are[Q_W-1:0] * w_aim[Q_W-1:0];

    assign w_sum = {1'b0, r_prr} + {1'b0, r_pii};

    assign w_p  = {{(Z_W - (PROD_W - FRAC)){1'b0}}, r_prr[PROD_W-1:FRAC]};
    assign w_q  = {{(Z_W - (PROD_W - FRAC)){1'b0}}, r_pii[PROD_W-1:FRAC]};
    assign w_x  = {{(Z_W - (PROD_W - FRAC + 1)){1'b0}}, r_pri[PROD_W-1:FRAC-1]};
    assign w_nr = w_p - w_q + Z_W'(r_cr);
    assign w_ni = (r_neg ? -w_x : w_x) + Z_W'(r_ci);

    assign w_cfg_ext = CW'(r_iter_cnt);

    // one result bit per step, consuming two radicand bits
    assign w_rem_sh = {r_rem[REM_W-3:0], r_val[PROD_W-1:PROD_W-2]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter_cnt <= CNT_W'(ITER_RST);
        end else if (i_cfg_we) begin
            r_iter_cnt <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cr    <= i_in.c_real;
            r_ci    <= i_in.c_imag;
            r_re    <= '0;
            r_im    <= '0;
            r_k     <= '0;
            r_esc_f <= 1'b0;
            r_lim   <= (w_cfg_ext > MAX_C) ? K_W'(MAX_C) : K_W'(w_cfg_ext);
        end
        if (i_cmd.mul) begin
            r_prr <= w_prr;
            r_pii <= w_pii;
            r_pri <= w_pri;
            r_big <= (|w_are[Z_W-1:Q_W]) || (|w_aim[Z_W-1:Q_W]);
            r_neg <= r_re[Z_W-1] ^ r_im[Z_W-1];
        end
        if (i_cmd.step) begin
            r_re <= w_nr;
            r_im <= w_ni;
            r_k  <= r_k + K_W'(1);
        end
        if (i_cmd.mark_esc) begin
            r_esc_f <= 1'b1;
        end
        if (i_cmd.sq_init) begin
            r_val    <= w_sum[PROD_W-1:0];
            r_rem    <= '0;
            r_root   <= '0;
            r_sq_cnt <= '0;
        end
        if (i_cmd.sq_step) begin
            r_val    <= {r_val[PROD_W-3:0], 2'b00};
            r_rem    <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root   <= {r_root[Q_W-2:0], w_ge};
            r_sq_cnt <= r_sq_cnt + SQ_CNT_W'(1);
        end
        if (i_cmd.res_ld) begin
            r_mag  <= r_esc_f ? '1 : r_root;
            r_escd <= r_esc_f;
        end
    end

    assign o_sts.esc     = r_big || w_sum[PROD_W];
    assign o_sts.last    = (r_k == r_lim);
    assign o_sts.sq_done = (r_sq_cnt == SQ_LAST);

    assign o_out.magnitude = r_mag;
    assign o_out.escaped   = r_escd;

endmodule

@@ hw/rtl/mandelbrot_orbit_magnitude.sv @@
// Runs the iteration loop for n effective iterations and then a square root,
// or goes straight to the result when the orbit escapes after step j.
// One request at a time; the next is taken in the cycle after the result moves
// to the output register. Each iteration step is a multiply, then an update;
// the square root follows the loop.
// Reset: synchronous, active low; iteration count returns to 100, no result held.
module mandelbrot_orbit_magnitude #(
    parameter int MAX_ITERATIONS = mom_pkg::MAX_ITER_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [mom_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  mom_pkg::t_in              i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output mom_pkg::t_out             o_out
);
    import mom_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    mom_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mom_datapath #(
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out      (o_out)
    );

endmodule

@@ hw/rtl/mom_checker.sv @@
module mom_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_cfg_we,
    input logic [mom_pkg::CNT_W-1:0] i_cfg_data,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input mom_pkg::t_in              i_in,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input mom_pkg::t_out             o_out
);
    import mom_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result dropped or changed while stalled");

    a_esc_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.escaped |-> o_out.magnitude == '1)
        else $error("escaped result not saturated");

    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while busy");

    a_min_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result appeared too early");

endmodule

bind mandelbrot_orbit_magnitude mom_checker u_chk (.*);
